// ----- rtl/core/rhtt_pkg.sv -----
`timescale 1ns / 1ps

package rhtt_pkg;

    // table geometry
    localparam int TABLE_ENTRIES = 32;
    localparam int IDX_BITS      = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CNT_BITS      = $clog2(TABLE_ENTRIES + 1);

    // item fields
    localparam int COORD_BITS  = 16;
    localparam int ID_BITS     = 16;
    localparam int CMD_BITS    = 3;
    localparam int STATUS_BITS = 2;

    // stream packing
    localparam int PAYLOAD_BITS = ID_BITS + 4 * COORD_BITS;
    localparam int TDATA_BITS   = ((PAYLOAD_BITS + 7) / 8) * 8;
    localparam int M_TUSER_BITS = STATUS_BITS + 1;

    typedef logic signed [COORD_BITS-1:0] coord_t;
    typedef logic [ID_BITS-1:0]           id_t;

    typedef struct packed {
        coord_t bottom;
        coord_t right;
        coord_t top;
        coord_t left;
    } rect_t;

    typedef struct packed {
        id_t   id;
        rect_t rect;
    } entry_t;

    localparam coord_t COORD_MAX = coord_t'({1'b0, {(COORD_BITS - 1){1'b1}}});
    localparam coord_t COORD_MIN = coord_t'({1'b1, {(COORD_BITS - 1){1'b0}}});

    typedef enum logic [CMD_BITS-1:0] {
        CMD_INSERT     = 3'd0,
        CMD_REMOVE     = 3'd1,
        CMD_CLEAR      = 3'd2,
        CMD_POINT      = 3'd3,
        CMD_RECT       = 3'd4,
        CMD_EXTENT     = 3'd5,
        CMD_UPPER_LEFT = 3'd6
    } cmd_t;

    typedef enum logic [STATUS_BITS-1:0] {
        ST_OK   = 2'd0,
        ST_FULL = 2'd1,
        ST_NONE = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE   = 2'd0,
        S_SCAN   = 2'd1,
        S_FINISH = 2'd2
    } state_t;

endpackage

// ----- rtl/core/rectangle_hit_test_table.sv -----
`timescale 1ns / 1ps

// rectangle hit-test table
// keeps up to TABLE_ENTRIES items, each an id with an inclusive rectangle, and answers
// insert, remove, clear, point query, rectangle query, extent and upper-left commands
// input channel s_axis: one transfer per command, the command code in tuser and the
// id and rectangle in tdata; a point query takes left as x and top as y
// output channel m_axis: status and found in tuser, id and rectangle in tdata, tlast on
// the final result of a command; a point or rectangle query gives one result per
// matching slot in slot order, or one not-found result, every other command exactly one
// result; all entries sit in one synchronous memory read one slot per cycle unless the
// scan is paused, valid marks in flops; clear and unknown codes go straight to the finish
// state, which loads their result into the output register; every other command needs
// a full pass over the table through the single memory read port
// one command at a time; the next input transfer is taken once the final result sits
// in the output register
// reset clears every valid mark, so the table starts empty with no clearing pass
// a stalled receiver holds the output register; the scan pauses on the next match until
// that result is taken, nothing is dropped or repeated

module rectangle_hit_test_table (
    input  logic                              clk,
    input  logic                              rst_n,
    // input command
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [rhtt_pkg::TDATA_BITS-1:0]   s_axis_tdata,  // item_id, left, top, right, bottom
    input  logic [rhtt_pkg::CMD_BITS-1:0]     s_axis_tuser,  // cmd
    // results
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [rhtt_pkg::TDATA_BITS-1:0]   m_axis_tdata,  // result_id, out_left, out_top,
                                                             // out_right, out_bottom
    output logic [rhtt_pkg::M_TUSER_BITS-1:0] m_axis_tuser,  // status, found
    output logic                              m_axis_tlast
);

    import rhtt_pkg::*;

    // control state
    state_t                state_reg, state_next;
    logic [TABLE_ENTRIES-1:0] valid_reg;

    // latched command
    cmd_t   cmd_reg;
    id_t    qid_reg;
    rect_t  qrect_reg;
    logic   qvalid_reg;

    // table memory and its read stage
    entry_t mem [TABLE_ENTRIES];
    entry_t rd_data_reg;
    logic [CNT_BITS-1:0] s_idx_reg;
    logic                d_vld_reg;
    logic [IDX_BITS-1:0] d_idx_reg;

    // scan accumulators
    logic                fm_vld_reg;   // first slot holding the id
    logic [IDX_BITS-1:0] fm_idx_reg;
    logic                ff_vld_reg;   // first free slot
    logic [IDX_BITS-1:0] ff_idx_reg;
    logic                sel_vld_reg;  // held match, best choice or extent
    entry_t              sel_reg;

    // output register
    logic    out_vld_reg;
    status_t out_status_reg;
    logic    out_found_reg;
    id_t     out_id_reg;
    rect_t   out_rect_reg;
    logic    out_last_reg;

    // input unpacking
    cmd_t  in_cmd;
    id_t   in_id;
    rect_t in_rect;

    // datapath signals
    rect_t   r;
    logic    slot_valid;
    logic    pt_hit;
    logic    rc_hit;
    logic    hit;
    logic    emit_mid;
    logic    out_free;
    logic    adv;
    logic    issue;
    logic    scan_done;
    logic    in_xfer;
    logic    fin_load;
    logic    mid_load;
    logic    wr_en;
    logic [IDX_BITS-1:0] wr_idx;

    status_t fin_status;
    logic    fin_found;
    id_t     fin_id;
    rect_t   fin_rect;

    always_comb
    begin
        in_cmd       = cmd_t'(s_axis_tuser);
        in_id        = s_axis_tdata[0 +: ID_BITS];
        in_rect.left   = s_axis_tdata[ID_BITS +: COORD_BITS];
        in_rect.top    = s_axis_tdata[ID_BITS + COORD_BITS +: COORD_BITS];
        in_rect.right  = s_axis_tdata[ID_BITS + 2 * COORD_BITS +: COORD_BITS];
        in_rect.bottom = s_axis_tdata[ID_BITS + 3 * COORD_BITS +: COORD_BITS];
    end

    // hit test on the slot coming out of the memory
    always_comb
    begin
        r          = rd_data_reg.rect;
        slot_valid = valid_reg[d_idx_reg];
        pt_hit     = (r.left <= qrect_reg.left) && (qrect_reg.left <= r.right)
                  && (r.top <= qrect_reg.top) && (qrect_reg.top <= r.bottom);
        rc_hit     = qvalid_reg && (r.left <= r.right) && (r.top <= r.bottom)
                  && !((qrect_reg.left > r.right) || (qrect_reg.right < r.left)
                    || (qrect_reg.top > r.bottom) || (qrect_reg.bottom < r.top));
        hit        = 1'b0;
        if (d_vld_reg && slot_valid)
        begin
            if (cmd_reg == CMD_POINT)
                hit = pt_hit;
            else if (cmd_reg == CMD_RECT)
                hit = rc_hit;
        end
        // a new hit pushes the held one out, which is then known not to be the last
        emit_mid = hit && sel_vld_reg;
        out_free = !out_vld_reg || m_axis_tready;
        adv      = !(emit_mid && !out_free);
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    if ((in_cmd == CMD_CLEAR) || (s_axis_tuser > CMD_BITS'(CMD_UPPER_LEFT)))
                        state_next = S_FINISH;
                    else
                        state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (scan_done)
                    state_next = S_FINISH;
            end
            S_FINISH:
            begin
                if (out_free)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control outputs of the sequencer
    always_comb
    begin
        s_axis_tready = (state_reg == S_IDLE);
        in_xfer       = s_axis_tvalid && s_axis_tready;
        issue         = (state_reg == S_SCAN) && (s_idx_reg < CNT_BITS'(TABLE_ENTRIES));
        scan_done     = (state_reg == S_SCAN) && !issue && (!d_vld_reg || adv);
        fin_load      = (state_reg == S_FINISH) && out_free;
        mid_load      = d_vld_reg && adv && emit_mid;
        wr_en         = fin_load && (cmd_reg == CMD_INSERT) && (fm_vld_reg || ff_vld_reg);
        wr_idx        = fm_vld_reg ? fm_idx_reg : ff_idx_reg;
    end

    // final result of a command
    always_comb
    begin
        fin_status = ST_OK;
        fin_found  = 1'b0;
        fin_id     = '0;
        fin_rect   = '0;
        unique case (cmd_reg)
            CMD_INSERT:
            begin
                fin_id = qid_reg;
                if (!(fm_vld_reg || ff_vld_reg))
                    fin_status = ST_FULL;
            end
            CMD_REMOVE:
            begin
                fin_id = qid_reg;
                if (!fm_vld_reg)
                    fin_status = ST_NONE;
            end
            CMD_POINT, CMD_RECT, CMD_UPPER_LEFT:
            begin
                if (sel_vld_reg)
                begin
                    fin_found = 1'b1;
                    fin_id    = sel_reg.id;
                    fin_rect  = sel_reg.rect;
                end
                else
                begin
                    fin_status = ST_NONE;
                end
            end
            CMD_EXTENT:
            begin
                fin_found = sel_vld_reg;
                fin_rect  = sel_reg.rect;
            end
            default:
            begin
                // clear and unused codes give an all-zero result
                fin_status = ST_OK;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            valid_reg   <= '0;
            s_idx_reg   <= '0;
            d_vld_reg   <= 1'b0;
            fm_vld_reg  <= 1'b0;
            ff_vld_reg  <= 1'b0;
            sel_vld_reg <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (in_xfer)
            begin
                s_idx_reg   <= '0;
                fm_vld_reg  <= 1'b0;
                ff_vld_reg  <= 1'b0;
                sel_vld_reg <= 1'b0;
            end

            if (adv)
            begin
                d_vld_reg <= issue;
                if (issue)
                    s_idx_reg <= s_idx_reg + 1'b1;
            end

            if (d_vld_reg && adv)
            begin
                if (slot_valid && (rd_data_reg.id == qid_reg) && !fm_vld_reg)
                    fm_vld_reg <= 1'b1;
                if (!slot_valid && !ff_vld_reg)
                    ff_vld_reg <= 1'b1;
                if (hit)
                    sel_vld_reg <= 1'b1;
                if (slot_valid && ((cmd_reg == CMD_EXTENT) || (cmd_reg == CMD_UPPER_LEFT)))
                    sel_vld_reg <= 1'b1;
            end

            // table updates land once the scan is over, so no read overlaps them
            if (fin_load)
            begin
                if (cmd_reg == CMD_CLEAR)
                    valid_reg <= '0;
                else if ((cmd_reg == CMD_REMOVE) && fm_vld_reg)
                    valid_reg[fm_idx_reg] <= 1'b0;
                else if (wr_en)
                    valid_reg[wr_idx] <= 1'b1;
            end

            if (mid_load || fin_load)
                out_vld_reg <= 1'b1;
            else if (m_axis_tready)
                out_vld_reg <= 1'b0;
        end
    end

    // table memory, one write port and one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_idx] <= {qid_reg, qrect_reg};
        if (issue && adv)
            rd_data_reg <= mem[s_idx_reg[IDX_BITS-1:0]];
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            cmd_reg        <= in_cmd;
            qid_reg        <= in_id;
            qrect_reg      <= in_rect;
            qvalid_reg     <= (in_rect.left <= in_rect.right) && (in_rect.top <= in_rect.bottom);
            // inverted maximum rectangle seeds the extent
            sel_reg.rect.left   <= COORD_MAX;
            sel_reg.rect.top    <= COORD_MAX;
            sel_reg.rect.right  <= COORD_MIN;
            sel_reg.rect.bottom <= COORD_MIN;
        end

        if (adv)
            d_idx_reg <= s_idx_reg[IDX_BITS-1:0];

        if (d_vld_reg && adv)
        begin
            if (slot_valid && (rd_data_reg.id == qid_reg) && !fm_vld_reg)
                fm_idx_reg <= d_idx_reg;
            if (!slot_valid && !ff_vld_reg)
                ff_idx_reg <= d_idx_reg;

            if (hit)
                sel_reg <= rd_data_reg;

            if (slot_valid && (cmd_reg == CMD_EXTENT))
            begin
                if (r.left < sel_reg.rect.left)
                    sel_reg.rect.left <= r.left;
                if (r.top < sel_reg.rect.top)
                    sel_reg.rect.top <= r.top;
                if (r.right > sel_reg.rect.right)
                    sel_reg.rect.right <= r.right;
                if (r.bottom > sel_reg.rect.bottom)
                    sel_reg.rect.bottom <= r.bottom;
            end

            // running upper-left rule, first valid slot taken without a comparison
            if (slot_valid && (cmd_reg == CMD_UPPER_LEFT)
                && (!sel_vld_reg
                    || ((r.left <= sel_reg.rect.left) && (r.top <= sel_reg.rect.top))))
                sel_reg <= rd_data_reg;
        end

        if (mid_load)
        begin
            out_status_reg <= ST_OK;
            out_found_reg  <= 1'b1;
            out_id_reg     <= sel_reg.id;
            out_rect_reg   <= sel_reg.rect;
            out_last_reg   <= 1'b0;
        end
        else if (fin_load)
        begin
            out_status_reg <= fin_status;
            out_found_reg  <= fin_found;
            out_id_reg     <= fin_id;
            out_rect_reg   <= fin_rect;
            out_last_reg   <= 1'b1;
        end
    end

    // output packing
    always_comb
    begin
        m_axis_tvalid = out_vld_reg;
        m_axis_tlast  = out_last_reg;
        m_axis_tuser  = {out_found_reg, out_status_reg};
        m_axis_tdata  = '0;
        m_axis_tdata[0 +: ID_BITS]                        = out_id_reg;
        m_axis_tdata[ID_BITS +: COORD_BITS]               = out_rect_reg.left;
        m_axis_tdata[ID_BITS + COORD_BITS +: COORD_BITS]     = out_rect_reg.top;
        m_axis_tdata[ID_BITS + 2 * COORD_BITS +: COORD_BITS] = out_rect_reg.right;
        m_axis_tdata[ID_BITS + 3 * COORD_BITS +: COORD_BITS] = out_rect_reg.bottom;
    end

endmodule

// ----- rtl/core/rhtt_checker.sv -----
`timescale 1ns / 1ps

module rhtt_checker (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              s_axis_tvalid,
    input logic                              s_axis_tready,
    input logic                              m_axis_tvalid,
    input logic                              m_axis_tready,
    input logic [rhtt_pkg::TDATA_BITS-1:0]   m_axis_tdata,
    input logic [rhtt_pkg::M_TUSER_BITS-1:0] m_axis_tuser,
    input logic                              m_axis_tlast
);

    import rhtt_pkg::*;

    // a stalled result keeps its payload
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready)
        |=> (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)))
        else $error("result changed while stalled");

    // one command at a time: no transfer right after one
    a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("input taken while a command is in flight");

    // only query matches continue a run, so results without an item close it
    a_nofound_last: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tuser[STATUS_BITS]) |-> m_axis_tlast)
        else $error("result without an item is not the last");

    // an error status never carries an item
    a_err_nofound: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && (m_axis_tuser[STATUS_BITS-1:0] != STATUS_BITS'(ST_OK)))
        |-> !m_axis_tuser[STATUS_BITS])
        else $error("error status with an item");

    // status code stays in range
    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> ((m_axis_tuser[STATUS_BITS-1:0] == STATUS_BITS'(ST_OK))
                        || (m_axis_tuser[STATUS_BITS-1:0] == STATUS_BITS'(ST_FULL))
                        || (m_axis_tuser[STATUS_BITS-1:0] == STATUS_BITS'(ST_NONE))))
        else $error("unknown status code");

endmodule

bind rectangle_hit_test_table rhtt_checker u_rhtt_checker (.*);
